[rtl/frk_pkg.sv]
// shared types, codes and constants of the frame ring with keep-last
package frk_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int TAG_W    = 32;
    localparam int POS_W    = 49;
    localparam int SER_W    = 31;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;
    localparam int UNREAD_W = 5;
    localparam int CFG_DW   = 5;
    localparam int CFG_IW   = 1;

    localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_NEXT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PREV  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd3;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_STOPPED = 2'd3;

    localparam logic [CFG_IW-1:0] CFG_KEEP_LAST = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_DEPTH     = 1'd1;

    localparam logic [CFG_DW-1:0] DEPTH_RESET = 5'd16;

    localparam logic signed [POS_W-1:0] POS_UNKNOWN = -49'sd1;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [POS_W-1:0] pos;
        logic [SER_W-1:0]        serial;
    } t_desc;

    localparam int DESC_W = $bits(t_desc);

endpackage

[rtl/frk_in_if.sv]
// input channel of the frame ring: action and frame descriptor
interface frk_in_if import frk_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [TAG_W-1:0]        frame_tag;
    logic signed [POS_W-1:0] frame_pos;
    logic [SER_W-1:0]        frame_serial;
    logic [SER_W-1:0]        stream_serial;
    logic                    player_stopped;

    modport source (
        output valid, action, frame_tag, frame_pos, frame_serial, stream_serial,
               player_stopped,
        input  ready
    );
    modport sink (
        input  valid, action, frame_tag, frame_pos, frame_serial, stream_serial,
               player_stopped,
        output ready
    );
endinterface

[rtl/frk_out_if.sv]
// result channel of the frame ring: status, counts and descriptors
interface frk_out_if import frk_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic [UNREAD_W-1:0]     unread_count;
    logic                    can_read;
    logic                    can_write;
    logic [TAG_W-1:0]        current_tag;
    logic signed [POS_W-1:0] current_pos;
    logic [SER_W-1:0]        current_serial;
    logic [TAG_W-1:0]        previous_tag;
    logic                    was_shown;
    logic signed [POS_W-1:0] last_shown_pos;

    modport source (
        output valid, status, unread_count, can_read, can_write, current_tag,
               current_pos, current_serial, previous_tag, was_shown, last_shown_pos,
        input  ready
    );
    modport sink (
        input  valid, status, unread_count, can_read, can_write, current_tag,
               current_pos, current_serial, previous_tag, was_shown, last_shown_pos,
        output ready
    );
endinterface

[rtl/frk_ram.sv]
// generic ram, one write port and two registered read ports
module frk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/frame_ring_keep_last.sv]
// frame ring top level: pointers, counters, descriptor ram and result register
// an accepted transaction reads the ram in the wait phase; in the result phase
// it enters the result register once that is free; only then is input ready again
// a depth_in_use write re-derives the read index bit by bit; input waits until done
// reset (synchronous, active low) empties the queue; slot contents are not cleared
module frame_ring_keep_last import frk_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    frk_in_if.sink            i_in,
    frk_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int EW  = (FW > CFG_DW) ? FW : CFG_DW;
    localparam int UW  = (FW > UNREAD_W) ? FW : UNREAD_W;
    localparam int CNW = $clog2(PW + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_RES  = 2'd2;

    // configuration
    logic              r_keep;
    logic [CFG_DW-1:0] r_depth;

    // queue state
    logic [PW-1:0] r_write, n_write;
    logic [PW-1:0] r_read, n_read;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_shown, n_shown;
    logic [PW-1:0] r_rd_mod, n_rd_mod;

    // read index reduction after a depth change
    logic          r_mod_busy;
    logic [PW-1:0] r_mod_q;
    logic [FW-1:0] r_mod_rem;
    logic [CNW-1:0] r_mod_cnt;
    logic [FW:0]   mod_try;
    logic [FW:0]   mod_next;

    // transaction in flight
    logic [1:0]          r_phase;
    logic [STAT_W-1:0]   r_p_status, n_status;
    logic [UNREAD_W-1:0] r_p_unread;
    logic                r_p_can_read;
    logic                r_p_can_write;
    logic                r_p_was, n_was;
    logic                r_p_has_unread;
    logic                r_p_has_fill;
    logic                r_p_shown;
    logic [SER_W-1:0]    r_p_serial;

    // result register
    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_o_status;
    logic [UNREAD_W-1:0]     r_o_unread;
    logic                    r_o_can_read;
    logic                    r_o_can_write;
    logic [TAG_W-1:0]        r_o_cur_tag;
    logic signed [POS_W-1:0] r_o_cur_pos;
    logic [SER_W-1:0]        r_o_cur_serial;
    logic [TAG_W-1:0]        r_o_prev_tag;
    logic                    r_o_was;
    logic signed [POS_W-1:0] r_o_last_pos;

    logic [EW-1:0] depth_ext;
    logic [FW-1:0] depth_eff;
    logic [PW:0]   depth_cmp;
    logic [PW:0]   write_inc;
    logic [PW:0]   read_inc;
    logic [PW:0]   rd_mod_inc;
    logic          push_ok;
    logic [FW-1:0] unread;
    logic [UW-1:0] unread_ext;
    logic          in_acc;
    logic          load_out;
    logic [PW-1:0] cur_addr;
    t_desc         wr_desc;
    t_desc         rd_cur;
    t_desc         rd_prv;
    logic [DESC_W-1:0] rd_cur_bits;
    logic [DESC_W-1:0] rd_prv_bits;

    // effective depth limited to 1..QUEUE_DEPTH
    always_comb begin
        depth_ext = EW'(r_depth);
        if (depth_ext == '0) begin
            depth_eff = FW'(1);
        end else if (depth_ext > EW'(QUEUE_DEPTH)) begin
            depth_eff = FW'(QUEUE_DEPTH);
        end else begin
            depth_eff = FW'(depth_ext);
        end
    end

    assign depth_cmp = (PW + 1)'(depth_eff);
    assign write_inc = {1'b0, r_write} + 1'b1;
    assign read_inc  = {1'b0, r_read} + 1'b1;

    always_comb begin
        n_write  = r_write;
        n_read   = r_read;
        n_fill   = r_fill;
        n_shown  = r_shown;
        n_rd_mod = r_rd_mod;
        n_status = ST_DONE;
        n_was    = 1'b0;
        push_ok  = 1'b0;
        unique case (i_in.action)
            ACT_PUSH: begin
                if (i_in.player_stopped) begin
                    n_status = ST_STOPPED;
                end else if (r_fill >= depth_eff) begin
                    n_status = ST_FULL;
                end else begin
                    push_ok = 1'b1;
                    n_write = (write_inc >= depth_cmp) ? '0 : write_inc[PW-1:0];
                    n_fill  = r_fill + 1'b1;
                end
            end
            ACT_NEXT: begin
                if (r_fill <= FW'(r_shown)) begin
                    n_status = ST_EMPTY;
                end else if (r_keep && !r_shown) begin
                    n_shown = 1'b1;
                end else begin
                    n_read   = (read_inc >= depth_cmp) ? '0 : read_inc[PW-1:0];
                    n_rd_mod = n_read;
                    n_fill   = r_fill - 1'b1;
                end
            end
            ACT_PREV: begin
                n_was   = r_shown;
                n_shown = 1'b0;
            end
            ACT_QUERY: begin
                n_status = ST_DONE;
            end
        endcase
        unread     = (n_fill > FW'(n_shown)) ? (n_fill - FW'(n_shown)) : '0;
        unread_ext = UW'(unread);
    end

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_phase == PH_IDLE) && !r_mod_busy;
    assign load_out    = (r_phase == PH_RES) && (!r_out_valid || o_out.ready);

    // current slot is (read + shown) mod depth, from the reduced read index
    assign rd_mod_inc = {1'b0, r_rd_mod} + 1'b1;
    assign cur_addr   = !r_shown ? r_rd_mod :
                        ((rd_mod_inc >= depth_cmp) ? '0 : rd_mod_inc[PW-1:0]);

    assign wr_desc.tag    = i_in.frame_tag;
    assign wr_desc.pos    = i_in.frame_pos;
    assign wr_desc.serial = i_in.frame_serial;

    frk_ram #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_we      (in_acc && push_ok),
        .i_waddr   (r_write),
        .i_wdata   (wr_desc),
        .i_raddr_a (cur_addr),
        .o_rdata_a (rd_cur_bits),
        .i_raddr_b (r_read),
        .o_rdata_b (rd_prv_bits)
    );

    assign rd_cur = t_desc'(rd_cur_bits);
    assign rd_prv = t_desc'(rd_prv_bits);

    // restoring remainder step, one dividend bit a cycle
    always_comb begin
        mod_try  = {r_mod_rem, r_mod_q[PW-1]};
        mod_next = (mod_try >= (FW + 1)'(depth_eff)) ?
                   (mod_try - (FW + 1)'(depth_eff)) : mod_try;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep     <= 1'b0;
            r_depth    <= DEPTH_RESET;
            r_write    <= '0;
            r_read     <= '0;
            r_fill     <= '0;
            r_shown    <= 1'b0;
            r_rd_mod   <= '0;
            r_mod_busy <= 1'b0;
            r_mod_cnt  <= '0;
            r_phase    <= PH_IDLE;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_KEEP_LAST) begin
                r_keep <= i_cfg_data[0];
            end
            if (i_cfg_we && i_cfg_index == CFG_DEPTH) begin
                r_depth    <= i_cfg_data;
                r_mod_busy <= 1'b1;
                r_mod_cnt  <= CNW'(PW);
            end else if (r_mod_busy) begin
                r_mod_cnt <= r_mod_cnt - 1'b1;
                if (r_mod_cnt == CNW'(1)) begin
                    r_mod_busy <= 1'b0;
                    r_rd_mod   <= PW'(mod_next);
                end
            end

            if (in_acc) begin
                r_write  <= n_write;
                r_read   <= n_read;
                r_fill   <= n_fill;
                r_shown  <= n_shown;
                r_rd_mod <= n_rd_mod;
            end

            unique case (r_phase)
                PH_IDLE: begin
                    if (in_acc) begin
                        r_phase <= PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    r_phase <= PH_RES;
                end
                PH_RES: begin
                    if (load_out) begin
                        r_phase <= PH_IDLE;
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    // remainder datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cfg_we && i_cfg_index == CFG_DEPTH) begin
            r_mod_q   <= r_read;
            r_mod_rem <= '0;
        end else if (r_mod_busy) begin
            r_mod_q   <= r_mod_q << 1;
            r_mod_rem <= FW'(mod_next);
        end
    end

    // transaction summary held until the ram data is back
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p_status     <= n_status;
            r_p_unread     <= unread_ext[UNREAD_W-1:0];
            r_p_can_read   <= (unread != '0) && !i_in.player_stopped;
            r_p_can_write  <= (n_fill < depth_eff) && !i_in.player_stopped;
            r_p_was        <= n_was;
            r_p_has_unread <= (unread != '0);
            r_p_has_fill   <= (n_fill != '0);
            r_p_shown      <= n_shown;
            r_p_serial     <= i_in.stream_serial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_status     <= r_p_status;
            r_o_unread     <= r_p_unread;
            r_o_can_read   <= r_p_can_read;
            r_o_can_write  <= r_p_can_write;
            r_o_was        <= r_p_was;
            r_o_cur_tag    <= r_p_has_unread ? rd_cur.tag : '0;
            r_o_cur_pos    <= r_p_has_unread ? rd_cur.pos : '0;
            r_o_cur_serial <= r_p_has_unread ? rd_cur.serial : '0;
            r_o_prev_tag   <= r_p_has_fill ? rd_prv.tag : '0;
            r_o_last_pos   <= (r_p_shown && r_p_has_fill && rd_prv.serial == r_p_serial) ?
                              rd_prv.pos : POS_UNKNOWN;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_o_status;
    assign o_out.unread_count   = r_o_unread;
    assign o_out.can_read       = r_o_can_read;
    assign o_out.can_write      = r_o_can_write;
    assign o_out.current_tag    = r_o_cur_tag;
    assign o_out.current_pos    = r_o_cur_pos;
    assign o_out.current_serial = r_o_cur_serial;
    assign o_out.previous_tag   = r_o_prev_tag;
    assign o_out.was_shown      = r_o_was;
    assign o_out.last_shown_pos = r_o_last_pos;

`ifndef SYNTHESIS
    // the fill count never passes the built depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= QUEUE_DEPTH)
        else $error("fill count beyond queue depth");

    // a shown mark always sits on a queued frame
    a_shown_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shown |-> (r_fill != '0))
        else $error("shown mark with empty queue");

    // an accepted transaction passes the wait phase and then reaches the result stage
    a_res_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> ##2 (r_phase == PH_RES))
        else $error("result stage not reached after accept");
`endif

endmodule
